### rtl/core/wsg_pkg.sv
// wsg_pkg: shared types and codes of the wavetable sound generator
// used by wsg_chan and wavetable_sound_generator, depends on nothing
package wsg_pkg;

    localparam int NCH  = 5;
    localparam int WLEN = 32;
    localparam int WDEP = NCH * WLEN;

    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;
    localparam logic [1:0] KIND_RSVD  = 2'd3;

    localparam logic [1:0] MODE_ORIG   = 2'd0;
    localparam logic [1:0] MODE_COMPAT = 2'd1;
    localparam logic [1:0] MODE_PLUS   = 2'd2;
    localparam logic [1:0] MODE_RSVD   = 2'd3;

    localparam logic [3:0] REG_VOL_FIRST = 4'hA;
    localparam logic [3:0] REG_ENABLE    = 4'hF;

    typedef struct packed {
        logic tick;
        logic enable;
        logic load;
        logic zero_ptr;
    } t_chan_ctl;

endpackage

### rtl/core/wsg_chan.sv
// wsg_chan: one voice - 32-byte wave store, period down counter, play pointer,
// serial multiplier and output latch; depends on wsg_pkg
module wsg_chan (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wsg_pkg::t_chan_ctl i_ctl,
    input  logic [1:0]        i_deform,
    input  logic [11:0]       i_period,
    input  logic [3:0]        i_volume,
    input  logic [7:0]        i_src,
    input  logic              i_wave_we,
    input  logic [4:0]        i_wave_addr,
    input  logic [7:0]        i_wave_data,
    input  logic [4:0]        i_rd_addr,
    output logic [7:0]        o_rd_byte,
    output logic [7:0]        o_cur_byte,
    output logic [4:0]        o_ptr,
    output logic [7:0]        o_level_nx
);

    logic [7:0]  r_wave [wsg_pkg::WLEN];
    logic [11:0] r_cnt, n_cnt;
    logic [4:0]  r_ptr, n_ptr;
    logic        r_run, n_run;
    logic [3:0]  r_idx, n_idx;
    logic [7:0]  r_gath, n_gath;
    logic [3:0]  r_vol, n_vol;
    logic [7:0]  r_level, n_level;
    logic [3:0]  hi;
    logic [7:0]  lo;
    logic        step;
    logic signed [12:0] prod;

    assign prod = $signed({{5{r_gath[7]}}, r_gath}) * $signed({9'd0, r_vol});

    always_comb begin
        n_cnt   = r_cnt;
        n_ptr   = r_ptr;
        n_run   = r_run;
        n_idx   = r_idx;
        n_gath  = r_gath;
        n_vol   = r_vol;
        n_level = r_level;
        hi      = r_cnt[11:8];
        lo      = r_cnt[7:0];
        step    = 1'b0;
        if (i_ctl.tick) begin
            if (i_ctl.enable && r_run) begin
                if (r_idx < 4'd8) begin
                    n_gath = r_gath | (i_src & (8'd1 << r_idx[2:0]));
                    n_idx  = r_idx + 4'd1;
                end else begin
                    n_level = prod[11:4];
                    n_run   = 1'b0;
                end
            end
            // period counter, 8-bit / 4-bit / full 12-bit forms
            if (i_deform[1]) begin
                if (lo == 8'd0) begin
                    step  = 1'b1;
                    n_cnt = i_period;
                end else begin
                    n_cnt = {(i_deform[0] ? hi - 4'd1 : hi), lo - 8'd1};
                end
            end else if (i_deform[0]) begin
                if (hi == 4'd0) begin
                    step  = 1'b1;
                    n_cnt = i_period;
                end else begin
                    n_cnt = {hi - 4'd1, lo - 8'd1};
                end
            end else begin
                if (r_cnt == 12'd0) begin
                    step  = 1'b1;
                    n_cnt = i_period;
                end else begin
                    n_cnt = r_cnt - 12'd1;
                end
            end
            if (step) begin
                n_ptr  = r_ptr + 5'd1;
                n_run  = 1'b1;
                n_idx  = 4'd0;
                n_gath = 8'd0;
                n_vol  = i_volume;
            end
            if (!i_ctl.enable) begin
                n_run   = 1'b0;
                n_idx   = 4'd0;
                n_gath  = 8'd0;
                n_level = 8'd0;
            end
        end else if (i_ctl.load) begin
            n_cnt = i_period;
            if (i_ctl.zero_ptr) begin
                n_ptr = 5'd0;
            end
            n_run  = 1'b1;
            n_idx  = 4'd0;
            n_gath = 8'd0;
            n_vol  = i_volume;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= 12'hFFF;
            r_ptr   <= 5'd0;
            r_run   <= 1'b0;
            r_idx   <= 4'd0;
            r_gath  <= 8'd0;
            r_vol   <= 4'd0;
            r_level <= 8'd0;
        end else begin
            r_cnt   <= n_cnt;
            r_ptr   <= n_ptr;
            r_run   <= n_run;
            r_idx   <= n_idx;
            r_gath  <= n_gath;
            r_vol   <= n_vol;
            r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < wsg_pkg::WLEN; i++) begin
                r_wave[i] <= 8'hFF;
            end
        end else if (i_wave_we) begin
            r_wave[i_wave_addr] <= i_wave_data;
        end
    end

    assign o_rd_byte  = r_wave[i_rd_addr];
    assign o_cur_byte = r_wave[r_ptr];
    assign o_ptr      = r_ptr;
    assign o_level_nx = n_level;

endmodule

### rtl/core/wavetable_sound_generator.sv
// wavetable_sound_generator: five-voice wavetable generator behind an 8-bit register window
// depends on wsg_pkg and wsg_chan
//
// channel  direction  handshake          words
// input    in         i_valid / o_ready  kind, bus address, write data
// output   out        o_valid / i_ready  read data, five voice levels, mix
// config   in         i_cfg_we           chip mode
//
// a new word every cycle while o_ready is high; word state updates at the accepting edge
// the result word is registered and offered the cycle after its input word is taken
// the result register frees the input side whenever it is empty or being taken
// reset is synchronous; the wave bytes are registers reset to 0xff, no clearing pass
module wavetable_sound_generator (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_kind,
    input  logic [7:0]        i_bus_address,
    input  logic [7:0]        i_write_data,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_read_data,
    output logic signed [7:0] o_chan1_level,
    output logic signed [7:0] o_chan2_level,
    output logic signed [7:0] o_chan3_level,
    output logic signed [7:0] o_chan4_level,
    output logic signed [7:0] o_chan5_level,
    output logic signed [10:0] o_mixed_level,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_data
);

    logic [1:0]  r_mode;
    logic [11:0] r_period [wsg_pkg::NCH];
    logic [11:0] n_period [wsg_pkg::NCH];
    logic [3:0]  r_volume [wsg_pkg::NCH];
    logic [3:0]  n_volume [wsg_pkg::NCH];
    logic [4:0]  r_enable, n_enable;
    logic [7:0]  r_deform, n_deform;
    logic [7:0]  r_shared [2];
    logic [7:0]  n_shared [2];
    logic [4:0]  r_phase;
    logic        r_ovalid;
    logic [7:0]  r_rdata, n_rdata;
    logic [7:0]  r_lv [wsg_pkg::NCH];
    logic [10:0] r_mix, n_mix;

    logic        accept, is_tick, is_read, is_write;
    logic [1:0]  mode;
    logic [1:0]  dv;
    logic [4:0]  ptr [wsg_pkg::NCH];
    logic [7:0]  lvl_nx [wsg_pkg::NCH];
    logic [7:0]  src [wsg_pkg::NCH];
    logic [7:0]  rd_byte [wsg_pkg::NCH];
    logic [7:0]  cur_byte [wsg_pkg::NCH];
    wsg_pkg::t_chan_ctl ctl [wsg_pkg::NCH];
    logic [4:0]  load;
    logic [4:0]  wave_we;
    logic [4:0]  rd_off;
    logic        wc_ok;
    logic [2:0]  wc;
    logic        rc_ok;
    logic [2:0]  rc;
    logic        fv, df, rdf;
    logic [3:0]  rg;
    logic [2:0]  pch;
    logic [4:0]  pidx;
    logic [7:0]  a;

    function automatic logic rot_of(input logic [1:0] f, input logic [2:0] ch);
        case (f)
            2'b01:   rot_of = 1'b1;
            2'b10:   rot_of = (ch >= 3'd3);
            2'b11:   rot_of = (ch < 3'd3);
            default: rot_of = 1'b0;
        endcase
    endfunction

    function automatic logic ro_of(input logic [1:0] f, input logic [2:0] ch);
        case (f)
            2'b01:   ro_of = 1'b1;
            2'b10:   ro_of = (ch >= 3'd3);
            2'b11:   ro_of = 1'b1;
            default: ro_of = 1'b0;
        endcase
    endfunction

    assign o_ready  = !r_ovalid || i_ready;
    assign accept   = i_valid && o_ready;
    assign is_tick  = accept && (i_kind == wsg_pkg::KIND_TICK);
    assign is_read  = accept && (i_kind == wsg_pkg::KIND_READ);
    assign is_write = accept && (i_kind == wsg_pkg::KIND_WRITE);
    assign a        = i_bus_address;
    assign mode     = (r_mode == wsg_pkg::MODE_ORIG)   ? wsg_pkg::MODE_ORIG :
                      (r_mode == wsg_pkg::MODE_COMPAT) ? wsg_pkg::MODE_COMPAT :
                                                         wsg_pkg::MODE_PLUS;
    assign dv       = {(mode == wsg_pkg::MODE_ORIG) ? r_deform[7] : 1'b0, r_deform[6]};

    // address decode
    always_comb begin
        wc_ok = 1'b0;
        wc    = {1'b0, a[6:5]};
        rc_ok = 1'b0;
        rc    = {1'b0, a[6:5]};
        fv    = 1'b0;
        df    = 1'b0;
        rdf   = 1'b0;
        unique case (mode)
            wsg_pkg::MODE_ORIG: begin
                wc_ok = (a < 8'h80);
                rc_ok = wc_ok;
                fv    = (a >= 8'h80) && (a < 8'hA0);
                df    = (a >= 8'hE0);
                rdf   = df;
            end
            wsg_pkg::MODE_COMPAT: begin
                wc_ok = (a < 8'h80);
                rc_ok = wc_ok || ((a >= 8'hA0) && (a < 8'hC0));
                rc    = wc_ok ? {1'b0, a[6:5]} : 3'd4;
                fv    = (a >= 8'h80) && (a < 8'hA0);
                df    = (a >= 8'hC0) && (a < 8'hE0);
                rdf   = df;
            end
            default: begin
                wc_ok = (a < 8'hA0);
                wc    = a[7:5];
                rc_ok = wc_ok;
                rc    = a[7:5];
                fv    = (a >= 8'hA0) && (a < 8'hC0);
                df    = (a >= 8'hC0) && (a < 8'hE0);
                rdf   = df;
            end
        endcase
    end

    // register writes, deformation set to 0xff on read, and wave write enables
    always_comb begin
        n_enable = r_enable;
        n_deform = r_deform;
        load     = 5'd0;
        wave_we  = 5'd0;
        rg       = a[3:0];
        pch      = rg[3:1];
        for (int i = 0; i < wsg_pkg::NCH; i++) begin
            n_period[i] = r_period[i];
            n_volume[i] = r_volume[i];
        end
        if (is_write) begin
            if (wc_ok) begin
                if (!ro_of(dv, wc)) begin
                    wave_we[wc] = 1'b1;
                    if ((mode != wsg_pkg::MODE_PLUS) && (wc == 3'd3)) begin
                        wave_we[4] = 1'b1;
                    end
                end
            end else if (fv) begin
                if (rg < wsg_pkg::REG_VOL_FIRST) begin
                    if (rg[0]) begin
                        n_period[pch] = {i_write_data[3:0], r_period[pch][7:0]};
                    end else begin
                        n_period[pch] = {r_period[pch][11:8], i_write_data};
                    end
                    load[pch] = 1'b1;
                end else if (rg < wsg_pkg::REG_ENABLE) begin
                    n_volume[3'(rg - wsg_pkg::REG_VOL_FIRST)] = i_write_data[3:0];
                end else begin
                    n_enable = i_write_data[4:0];
                end
            end else if (df) begin
                n_deform = i_write_data;
            end
        end
        if (is_read && rdf) begin
            n_deform = 8'hFF;
        end
    end

    // read data
    always_comb begin
        n_rdata = 8'hFF;
        pidx    = ptr[rc];
        if ((rc == 3'd3) && (mode != wsg_pkg::MODE_PLUS) && (r_deform[7:6] == 2'b01)) begin
            pidx = ptr[4];
        end
        rd_off = rot_of(dv, rc) ? pidx : a[4:0];
        if (is_read && rc_ok) begin
            n_rdata = rd_byte[rc];
        end
    end

    // voice sources and shared latch capture
    always_comb begin
        n_shared[0] = r_shared[0];
        n_shared[1] = r_shared[1];
        for (int i = 0; i < wsg_pkg::NCH; i++) begin
            src[i] = cur_byte[i];
        end
        if (mode == wsg_pkg::MODE_ORIG) begin
            src[3] = r_shared[0];
            src[4] = r_shared[1];
            if (is_tick && (r_phase == 5'd0)) begin
                n_shared[0] = cur_byte[3];
            end
            if (is_tick && (r_phase == 5'd16)) begin
                n_shared[1] = cur_byte[4];
            end
        end
    end

    always_comb begin
        n_mix = 11'd0;
        for (int i = 0; i < wsg_pkg::NCH; i++) begin
            n_mix = n_mix + {{3{lvl_nx[i][7]}}, lvl_nx[i]};
        end
    end

    for (genvar g = 0; g < wsg_pkg::NCH; g++) begin : g_chan
        always_comb begin
            ctl[g].tick     = is_tick;
            ctl[g].enable   = r_enable[g];
            ctl[g].load     = load[g];
            ctl[g].zero_ptr = r_deform[5];
        end
        wsg_chan u_chan (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (ctl[g]),
            .i_deform    (r_deform[1:0]),
            .i_period    (n_period[g]),
            .i_volume    (r_volume[g]),
            .i_src       (src[g]),
            .i_wave_we   (wave_we[g]),
            .i_wave_addr (a[4:0]),
            .i_wave_data (i_write_data),
            .i_rd_addr   (rd_off),
            .o_rd_byte   (rd_byte[g]),
            .o_cur_byte  (cur_byte[g]),
            .o_ptr       (ptr[g]),
            .o_level_nx  (lvl_nx[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= wsg_pkg::MODE_ORIG;
            r_enable  <= 5'd0;
            r_deform  <= 8'd0;
            r_shared  <= '{8'hFF, 8'hFF};
            r_phase   <= 5'd0;
            r_ovalid  <= 1'b0;
            for (int i = 0; i < wsg_pkg::NCH; i++) begin
                r_period[i] <= 12'd0;
                r_volume[i] <= 4'd15;
            end
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end
            r_enable  <= n_enable;
            r_deform  <= n_deform;
            r_shared  <= n_shared;
            r_period  <= n_period;
            r_volume  <= n_volume;
            if (is_tick) begin
                r_phase <= r_phase + 5'd1;
            end
            if (accept) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rdata <= n_rdata;
            r_lv    <= lvl_nx;
            r_mix   <= n_mix;
        end
    end

    assign o_valid       = r_ovalid;
    assign o_read_data   = r_rdata;
    assign o_chan1_level = r_lv[0];
    assign o_chan2_level = r_lv[1];
    assign o_chan3_level = r_lv[2];
    assign o_chan4_level = r_lv[3];
    assign o_chan5_level = r_lv[4];
    assign o_mixed_level = r_mix;

endmodule

### test/wavetable_sound_generator_tb.sv
// wavetable_sound_generator_tb: self-checking bench for the five-voice wavetable generator
// holds its own cycle model of the chip and checks every output word against it
// depends on wsg_pkg and wavetable_sound_generator
module wavetable_sound_generator_tb;

    typedef struct {
        logic [1:0] kind;
        logic [7:0] addr;
        logic [7:0] data;
    } t_bus_word;

    typedef struct {
        logic [7:0]  rd;
        logic [7:0]  lvl[wsg_pkg::NCH];
        logic [10:0] mix;
    } t_out_word;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic [1:0] i_kind = wsg_pkg::KIND_TICK;
    logic [7:0] i_bus_address = 8'h00;
    logic [7:0] i_write_data = 8'h00;
    logic i_ready = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_data = wsg_pkg::MODE_ORIG;
    logic o_ready, o_valid;
    logic [7:0] o_read_data;
    logic signed [7:0] o_chan1_level, o_chan2_level, o_chan3_level, o_chan4_level;
    logic signed [7:0] o_chan5_level;
    logic signed [10:0] o_mixed_level;

    wavetable_sound_generator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_kind(i_kind), .i_bus_address(i_bus_address), .i_write_data(i_write_data),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_read_data(o_read_data),
        .o_chan1_level(o_chan1_level), .o_chan2_level(o_chan2_level),
        .o_chan3_level(o_chan3_level), .o_chan4_level(o_chan4_level),
        .o_chan5_level(o_chan5_level), .o_mixed_level(o_mixed_level),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    t_bus_word bus_words[$];
    t_out_word expected_outputs[$];
    int errors = 0;
    int words_checked = 0;
    int reads_seen = 0;

    // chip model state
    logic [1:0]  mode_reg;
    logic [7:0]  wave_mem[wsg_pkg::WDEP];
    logic [11:0] period[wsg_pkg::NCH];
    logic [11:0] freq_cnt[wsg_pkg::NCH];
    logic [3:0]  volume[wsg_pkg::NCH];
    logic [3:0]  mul_vol[wsg_pkg::NCH];
    logic [4:0]  voice_on;
    logic [7:0]  deform;
    logic [4:0]  ptr[wsg_pkg::NCH];
    bit          mul_busy[wsg_pkg::NCH];
    int          mul_bit[wsg_pkg::NCH];
    logic [7:0]  mul_acc[wsg_pkg::NCH];
    logic [7:0]  level[wsg_pkg::NCH];
    logic [7:0]  shared_byte[2];
    logic [4:0]  frame;

    function automatic logic [1:0] eff_mode();
        return (mode_reg >= wsg_pkg::MODE_PLUS) ? wsg_pkg::MODE_PLUS : mode_reg;
    endfunction

    task automatic chip_reset();
        mode_reg = wsg_pkg::MODE_ORIG;
        foreach (wave_mem[i]) wave_mem[i] = 8'hFF;
        for (int c = 0; c < wsg_pkg::NCH; c++) begin
            period[c] = 0; volume[c] = 4'hF; freq_cnt[c] = 12'hFFF; ptr[c] = 0;
            mul_busy[c] = 0; mul_bit[c] = 0; mul_acc[c] = 0; mul_vol[c] = 0; level[c] = 0;
        end
        voice_on = 0; deform = 0; shared_byte[0] = 8'hFF; shared_byte[1] = 8'hFF; frame = 0;
    endtask

    // {rotate, read-only}
    function automatic logic [1:0] wave_flags(int c);
        logic [7:0] v;
        v = deform;
        if (eff_mode() != wsg_pkg::MODE_ORIG) v[7] = 1'b0;
        case (v[7:6])
            2'b01: return 2'b11;
            2'b10: return (c >= 3) ? 2'b11 : 2'b00;
            2'b11: return {c < 3, 1'b1};
            default: return 2'b00;
        endcase
    endfunction

    function automatic int wave_chan(logic [7:0] a, bit wr);
        if (eff_mode() == wsg_pkg::MODE_ORIG) return (a < 8'h80) ? int'(a >> 5) : -1;
        if (eff_mode() == wsg_pkg::MODE_COMPAT) begin
            if (a < 8'h80) return int'(a >> 5);
            if (!wr && a >= 8'hA0 && a < 8'hC0) return 4;
            return -1;
        end
        return (a < 8'hA0) ? int'(a >> 5) : -1;
    endfunction

    function automatic bit freq_step(int c);
        logic [11:0] org, cnt;
        logic [3:0] hi;
        logic [7:0] lo;
        bit st;
        org = period[c]; cnt = freq_cnt[c]; hi = cnt[11:8]; lo = cnt[7:0]; st = 0;
        if (deform[1]) begin
            if (lo == 0) begin
                st = 1; hi = org[11:8]; lo = org[7:0];
            end else begin
                lo = lo - 8'd1;
                if (deform[0]) hi = hi - 4'd1;
            end
        end else if (deform[0]) begin
            if (hi == 0) begin
                st = 1; hi = org[11:8]; lo = org[7:0];
            end else begin
                hi = hi - 4'd1; lo = lo - 8'd1;
            end
        end else begin
            if (cnt == 0) begin
                st = 1; cnt = org;
            end else cnt = cnt - 12'd1;
            hi = cnt[11:8]; lo = cnt[7:0];
        end
        freq_cnt[c] = {hi, lo};
        return st;
    endfunction

    function automatic void start_mul(int c);
        mul_busy[c] = 1; mul_bit[c] = 0; mul_acc[c] = 0; mul_vol[c] = volume[c];
    endfunction

    function automatic logic [7:0] scaled(logic [7:0] w, logic [3:0] v);
        int p;
        p = int'($signed(w)) * int'(v) + 2048;
        return 8'(((p >>> 4) - 128) & 255);
    endfunction

    function automatic void clock_tick();
        int edge_no;
        bit on, latched;
        logic [7:0] src;
        edge_no = int'(frame) + 1;
        for (int c = 0; c < wsg_pkg::NCH; c++) begin
            on = voice_on[c];
            latched = (eff_mode() == wsg_pkg::MODE_ORIG) && (c >= 3);
            if (on && mul_busy[c]) begin
                if (mul_bit[c] < 8) begin
                    src = latched ? shared_byte[c-3] : wave_mem[c*wsg_pkg::WLEN + ptr[c]];
                    mul_acc[c][mul_bit[c]] = src[mul_bit[c]];
                    mul_bit[c]++;
                end else begin
                    level[c] = scaled(mul_acc[c], mul_vol[c]);
                    mul_busy[c] = 0;
                end
            end
            if (latched && edge_no == ((c == 3) ? 1 : 17))
                shared_byte[c-3] = wave_mem[c*wsg_pkg::WLEN + ptr[c]];
            if (freq_step(c)) begin
                ptr[c] = ptr[c] + 5'd1;
                start_mul(c);
            end
            if (!on) begin
                mul_busy[c] = 0; mul_bit[c] = 0; mul_acc[c] = 0; level[c] = 0;
            end
        end
        frame = frame + 5'd1;
    endfunction

    function automatic void bus_write(logic [7:0] a, logic [7:0] v);
        int wc, c;
        bit fv, df;
        logic [1:0] fl;
        wc = wave_chan(a, 1);
        if (wc >= 0) begin
            fl = wave_flags(wc);
            if (!fl[0]) begin
                wave_mem[wc*wsg_pkg::WLEN + a[4:0]] = v;
                if (eff_mode() != wsg_pkg::MODE_PLUS && wc == 3)
                    wave_mem[4*wsg_pkg::WLEN + a[4:0]] = v;
            end
            return;
        end
        if (eff_mode() == wsg_pkg::MODE_PLUS) begin
            fv = a >= 8'hA0 && a < 8'hC0; df = a >= 8'hC0 && a < 8'hE0;
        end else if (eff_mode() == wsg_pkg::MODE_COMPAT) begin
            fv = a >= 8'h80 && a < 8'hA0; df = a >= 8'hC0 && a < 8'hE0;
        end else begin
            fv = a >= 8'h80 && a < 8'hA0; df = a >= 8'hE0;
        end
        if (fv) begin
            if (a[3:0] < wsg_pkg::REG_VOL_FIRST) begin
                c = a[3:1];
                if (a[0]) period[c][11:8] = v[3:0];
                else period[c][7:0] = v;
                freq_cnt[c] = period[c];
                if (deform[5]) ptr[c] = 0;
                start_mul(c);
            end else if (a[3:0] < wsg_pkg::REG_ENABLE) begin
                volume[a[3:0] - wsg_pkg::REG_VOL_FIRST] = v[3:0];
            end else begin
                voice_on = v[4:0];
            end
        end else if (df) begin
            deform = v;
        end
    endfunction

    function automatic logic [7:0] bus_read(logic [7:0] a);
        int wc, p;
        logic [1:0] fl;
        if ((eff_mode() == wsg_pkg::MODE_ORIG && a >= 8'hE0) ||
            (eff_mode() != wsg_pkg::MODE_ORIG && a >= 8'hC0 && a < 8'hE0))
            deform = 8'hFF;
        wc = wave_chan(a, 0);
        if (wc < 0) return 8'hFF;
        fl = wave_flags(wc);
        if (!fl[1]) return wave_mem[wc*wsg_pkg::WLEN + a[4:0]];
        p = wc;
        if (wc == 3 && eff_mode() != wsg_pkg::MODE_PLUS && deform[7:6] == 2'b01) p = 4;
        return wave_mem[wc*wsg_pkg::WLEN + ptr[p]];
    endfunction

    function automatic t_out_word chip_step(t_bus_word w);
        t_out_word r;
        int sum;
        r.rd = 8'hFF;
        if (w.kind == wsg_pkg::KIND_TICK) clock_tick();
        else if (w.kind == wsg_pkg::KIND_READ) r.rd = bus_read(w.addr);
        else if (w.kind == wsg_pkg::KIND_WRITE) bus_write(w.addr, w.data);
        sum = 0;
        for (int c = 0; c < wsg_pkg::NCH; c++) begin
            r.lvl[c] = level[c];
            sum += int'($signed(level[c]));
        end
        r.mix = 11'(sum);
        return r;
    endfunction

    // sender: bursts of random length with random gaps
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge i_clk) begin
        t_bus_word w;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                w.kind = i_kind; w.addr = i_bus_address; w.data = i_write_data;
                expected_outputs.insert(expected_outputs.size(), chip_step(w));
            end
            if (!i_valid || o_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (bus_words.size() > 0) begin
                    w = bus_words.pop_front();
                    i_kind <= w.kind; i_bus_address <= w.addr; i_write_data <= w.data;
                    i_valid <= 1'b1;
                    if (burst_left > 0) burst_left--;
                    else begin
                        burst_left = $urandom_range(0, 3) == 0 ? 200 : $urandom_range(1, 30);
                        gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: own stall pattern plus one long hold-off
    int rx_cycle = 0;
    int rx_hold = 0;

    always @(posedge i_clk) begin
        rx_cycle++;
        if (rx_hold > 0) begin
            rx_hold--;
            i_ready <= 1'b0;
        end else if (rx_cycle == 2500) begin
            rx_hold = 300;
            i_ready <= 1'b0;
        end else begin
            case ((rx_cycle / 400) % 4)
                0: i_ready <= 1'b1;
                1: i_ready <= 1'($urandom_range(0, 1));
                2: i_ready <= (rx_cycle % 4) != 0;
                default: i_ready <= $urandom_range(0, 4) != 0;
            endcase
        end
    end

    function automatic void check_field(string name, logic [10:0] exp_v, logic [10:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_word e;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_outputs.size() == 0) begin
                $error("output word with nothing expected");
                errors++;
            end else begin
                e = expected_outputs.pop_front();
                words_checked++;
                check_field("read_data", 11'(e.rd), 11'(o_read_data));
                check_field("chan1_level", 11'(e.lvl[0]), 11'($unsigned(o_chan1_level)));
                check_field("chan2_level", 11'(e.lvl[1]), 11'($unsigned(o_chan2_level)));
                check_field("chan3_level", 11'(e.lvl[2]), 11'($unsigned(o_chan3_level)));
                check_field("chan4_level", 11'(e.lvl[3]), 11'($unsigned(o_chan4_level)));
                check_field("chan5_level", 11'(e.lvl[4]), 11'($unsigned(o_chan5_level)));
                check_field("mixed_level", e.mix, $unsigned(o_mixed_level));
            end
        end
    end

    task automatic push_word(logic [1:0] k, logic [7:0] a, logic [7:0] d);
        t_bus_word w;
        w.kind = k; w.addr = a; w.data = d;
        if (k == wsg_pkg::KIND_READ) reads_seen++;
        bus_words.insert(bus_words.size(), w);
    endtask

    task automatic push_random(logic [1:0] m);
        logic [7:0] fv_base, df_base, wave_top;
        int r;
        fv_base = (m >= wsg_pkg::MODE_PLUS) ? 8'hA0 : 8'h80;
        df_base = (m == wsg_pkg::MODE_ORIG) ? 8'hE0 : 8'hC0;
        wave_top = (m >= wsg_pkg::MODE_PLUS) ? 8'h9F : 8'h7F;
        r = $urandom_range(0, 99);
        if (r < 55) push_word(wsg_pkg::KIND_TICK, 8'($urandom), 8'($urandom));
        else if (r < 62)
            push_word(wsg_pkg::KIND_WRITE, 8'(fv_base + $urandom_range(0, 9)),
                      $urandom_range(0, 5) == 0 ? 8'($urandom) : 8'($urandom_range(0, 12)));
        else if (r < 68)
            push_word(wsg_pkg::KIND_WRITE, 8'(fv_base + $urandom_range(10, 15)),
                      8'($urandom));
        else if (r < 78)
            push_word(wsg_pkg::KIND_WRITE, 8'($urandom_range(0, wave_top)), 8'($urandom));
        else if (r < 81)
            push_word(wsg_pkg::KIND_WRITE, 8'(df_base + $urandom_range(0, 31)),
                      $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom & 8'h23));
        else if (r < 93)
            push_word(wsg_pkg::KIND_READ, 8'($urandom_range(0, 8'hBF)), 8'($urandom));
        else if (r < 95)
            push_word(wsg_pkg::KIND_READ, 8'(df_base + $urandom_range(0, 31)), 8'($urandom));
        else if (r < 98) push_word(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
        else push_word(wsg_pkg::KIND_RSVD, 8'($urandom), 8'($urandom));
    endtask

    task automatic wait_drained();
        while (bus_words.size() > 0 || i_valid || expected_outputs.size() > 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_mode(logic [1:0] m);
        i_cfg_we <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        mode_reg = m;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    logic [1:0] mode_plan[5] = '{wsg_pkg::MODE_ORIG, wsg_pkg::MODE_PLUS, wsg_pkg::MODE_COMPAT,
                                 wsg_pkg::MODE_RSVD, wsg_pkg::MODE_ORIG};

    initial begin
        chip_reset();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, rotation, deformation read, ignored kind
        push_word(wsg_pkg::KIND_WRITE, 8'h8F, 8'hFF);
        push_word(wsg_pkg::KIND_WRITE, 8'h80, 8'h00);
        push_word(wsg_pkg::KIND_WRITE, 8'h82, 8'h01);
        push_word(wsg_pkg::KIND_WRITE, 8'h87, 8'h0F);
        push_word(wsg_pkg::KIND_WRITE, 8'h00, 8'h80);
        push_word(wsg_pkg::KIND_WRITE, 8'h21, 8'h7F);
        push_word(wsg_pkg::KIND_WRITE, 8'h60, 8'h00);
        push_word(wsg_pkg::KIND_WRITE, 8'h8A, 8'h00);
        push_word(wsg_pkg::KIND_WRITE, 8'h8E, 8'hFF);
        push_word(wsg_pkg::KIND_READ, 8'h00, 8'h00);
        push_word(wsg_pkg::KIND_READ, 8'hFF, 8'h00);
        for (int i = 0; i < 6; i++) push_word(wsg_pkg::KIND_TICK, 8'h00, 8'h00);
        push_word(wsg_pkg::KIND_WRITE, 8'hE0, 8'h40);
        push_word(wsg_pkg::KIND_READ, 8'h61, 8'h00);
        push_word(wsg_pkg::KIND_WRITE, 8'h61, 8'h55);
        push_word(wsg_pkg::KIND_WRITE, 8'hE5, 8'h23);
        push_word(wsg_pkg::KIND_WRITE, 8'h81, 8'h00);
        push_word(wsg_pkg::KIND_RSVD, 8'hFF, 8'hFF);
        push_word(wsg_pkg::KIND_READ, 8'hE3, 8'hFF);
        push_word(wsg_pkg::KIND_WRITE, 8'hFF, 8'h00);

        foreach (mode_plan[p]) begin
            if (p > 0) set_mode(mode_plan[p]);
            for (int i = 0; i < 365; i++) push_random(mode_plan[p]);
            wait_drained();
        end

        repeat (20) @(posedge i_clk);
        $display("checked %0d output words, %0d of them bus reads,", words_checked, reads_seen);
        $display("over all chip modes with bursty input and stalled output");
        if (errors == 0 && expected_outputs.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
